// ===== sv/hmm_pkg.sv =====
// Package with shared types, constants and a decode helper for the memory map block.
`timescale 1ns / 1ps
package hmm_pkg;

    localparam int VideoRamBytes = 8192;
    localparam int WorkRamBytes  = 8192;

    typedef enum logic [3:0] {
        REG_ROM    = 4'd0,
        REG_VRAM   = 4'd1,
        REG_EXTRAM = 4'd2,
        REG_WRAM   = 4'd3,
        REG_ECHO   = 4'd4,
        REG_OAM    = 4'd5,
        REG_UNUSED = 4'd6,
        REG_IO     = 4'd7,
        REG_HRAM   = 4'd8,
        REG_IE     = 4'd9
    } t_region;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DENIED = 2'd1,
        ST_WONLY  = 2'd2,
        ST_RONLY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        FWD_NONE   = 3'd0,
        FWD_CART   = 3'd1,
        FWD_EXTRAM = 3'd2,
        FWD_DMA    = 3'd3,
        FWD_BOOT   = 3'd4
    } t_fwd;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_DIV  = 2'd2,
        SRC_LINE = 2'd3
    } t_src;

    localparam logic CFG_DOCTOR_MODE = 1'b0;

    localparam logic [7:0] JOYP_RESET = 8'hEF;
    localparam logic [7:0] LINE_FORCE = 8'h90;

    typedef struct packed {
        logic        req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  divider_now;
        logic [7:0]  line_now;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] region;
        logic [1:0] status;
        logic [2:0] forward_kind;
        logic       divider_reset;
    } t_rsp;

    // Result of decoding one I/O access.
    typedef struct packed {
        t_status    status;
        t_fwd       fwd;
        logic       divr;
        logic       wen;
        logic [7:0] wmask;   // bits that take the written byte
        logic [7:0] wkeep;   // bits kept from the old value
        logic [7:0] rmask;
        t_src       src;
    } t_io_dec;

    function automatic t_io_dec io_decode(input logic wr, input logic [6:0] off);
        t_io_dec r;
        r = '{status: ST_OK, fwd: FWD_NONE, divr: 1'b0, wen: 1'b0,
              wmask: 8'hFF, wkeep: 8'h00, rmask: 8'hFF, src: SRC_MEM};
        if (wr) begin
            r.src = SRC_ZERO;
            case (off)
                7'h00: begin r.wen = 1'b1; r.wmask = 8'h30; r.wkeep = 8'hCF; end
                7'h04: begin r.wen = 1'b1; r.wmask = 8'h00; r.divr = 1'b1; end
                7'h07: begin r.wen = 1'b1; r.wmask = 8'h07; end
                7'h14, 7'h19: begin r.wen = 1'b1; r.wmask = 8'hC7; end
                7'h26: begin r.wen = 1'b1; r.wmask = 8'h80; r.wkeep = 8'h7F; end
                7'h41: begin r.wen = 1'b1; r.wmask = 8'h78; end
                7'h44: r.status = ST_RONLY;
                7'h46: begin r.wen = 1'b1; r.fwd = FWD_DMA; end
                7'h50: begin r.wen = 1'b1; r.fwd = FWD_BOOT; end
                7'h4D, 7'h7F: r.wen = 1'b0;
                7'h01, 7'h02, 7'h05, 7'h06, 7'h0F, 7'h10, 7'h11, 7'h12, 7'h13,
                7'h16, 7'h17, 7'h18, 7'h1A, 7'h1B, 7'h1C, 7'h1D, 7'h1E, 7'h20,
                7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h40, 7'h42, 7'h43, 7'h45,
                7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B: r.wen = 1'b1;
                default: begin
                    if (off[6:4] == 3'b011) r.wen = 1'b1;
                    else r.status = ST_DENIED;
                end
            endcase
        end else begin
            case (off)
                7'h04: r.src = SRC_DIV;
                7'h44: r.src = SRC_LINE;
                7'h4D: r.src = SRC_ZERO;
                7'h07: r.rmask = 8'h07;
                7'h11, 7'h16: r.rmask = 8'hC0;
                7'h14, 7'h19, 7'h1E, 7'h23: r.rmask = 8'h40;
                7'h13, 7'h18, 7'h1B, 7'h1D, 7'h20: begin
                    r.status = ST_WONLY; r.src = SRC_ZERO;
                end
                7'h00, 7'h01, 7'h02, 7'h05, 7'h06, 7'h0F, 7'h10, 7'h12, 7'h17,
                7'h1A, 7'h1C, 7'h21, 7'h22, 7'h24, 7'h25, 7'h26, 7'h40, 7'h41,
                7'h42, 7'h43, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
                7'h4B: r.src = SRC_MEM;
                default: begin
                    if (off[6:4] != 3'b011) begin
                        r.status = ST_DENIED; r.src = SRC_ZERO;
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ===== sv/hmm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module hmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/handheld_memory_map_io_registers.sv =====
// Top level: bus decoder with video, work, sprite, high RAM and the I/O register file.
//
//  channel  direction  handshake        payload
//  request  in         i_valid/o_stall  i_req (t_req)
//  result   out        o_valid/i_stall  o_rsp (t_rsp)
//  config   in         APB              doctor_mode at address 0
//
// Each access has a read cycle on the addressed memory, then a
// modify/write-back cycle that also forms the result. A new request is taken
// only when no access is in flight, so an access is not taken before the
// one ahead of it has formed its result. Reset clears the control state and
// the per-entry written flags of the I/O file; an entry not yet written reads
// as its reset value, the joypad default or zero.
// A stalled result holds in the output register and stalls the input.
`timescale 1ns / 1ps
module handheld_memory_map_io_registers
    import hmm_pkg::*;
#(
    parameter int VIDEO_RAM_BYTES = VideoRamBytes,
    parameter int WORK_RAM_BYTES  = WorkRamBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VAW = $clog2(VIDEO_RAM_BYTES);
    localparam int WAW = $clog2(WORK_RAM_BYTES);

    logic   r_doctor;
    logic   r_busy, n_busy;
    logic   r_ovalid, n_ovalid;
    t_req   r_req;
    t_rsp   r_rsp, n_rsp;
    logic [7:0] r_ie;
    // The I/O file resets to zero except the joypad byte; one written flag per
    // entry selects between the RAM contents and that reset value.
    logic   r_io_valid [128];

    logic   accept;
    logic   wr;
    logic [15:0] a;
    t_region reg_d;
    t_io_dec iod;

    logic [7:0] vram_q, wram_q, oam_q, hram_q, io_q, io_old;
    logic vram_we, wram_we, oam_we, hram_we, io_we;
    logic [7:0] io_wdata;
    logic [15:0] vidx, widx;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_doctor};
    assign o_stall = r_busy || (r_ovalid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doctor <= 1'b0;
        end else if (psel && penable && pwrite && paddr == CFG_DOCTOR_MODE) begin
            r_doctor <= pwdata[0];
        end
    end

    // Address for the memory read: the incoming request in its first cycle.
    t_req mreq;
    assign mreq = r_busy ? r_req : i_req;
    assign vidx = mreq.address - 16'h8000;
    assign widx = mreq.address - 16'hC000;

    assign wr = r_req.req_type;
    assign a  = r_req.address;

    always_comb begin
        if      (a <= 16'h7FFF) reg_d = REG_ROM;
        else if (a <= 16'h9FFF) reg_d = REG_VRAM;
        else if (a <= 16'hBFFF) reg_d = REG_EXTRAM;
        else if (a <= 16'hDFFF) reg_d = REG_WRAM;
        else if (a <= 16'hFDFF) reg_d = REG_ECHO;
        else if (a <= 16'hFE9F) reg_d = REG_OAM;
        else if (a <= 16'hFEFF) reg_d = REG_UNUSED;
        else if (a <= 16'hFF7F) reg_d = REG_IO;
        else if (a <= 16'hFFFE) reg_d = REG_HRAM;
        else                    reg_d = REG_IE;
    end

    assign iod    = io_decode(wr, a[6:0]);
    assign io_old = r_io_valid[a[6:0]] ? io_q : ((a[6:0] == 7'd0) ? JOYP_RESET : 8'h00);
    assign io_wdata = (io_old & iod.wkeep) | (r_req.write_data & iod.wmask);

    assign vram_we = r_busy && wr && reg_d == REG_VRAM;
    assign wram_we = r_busy && wr && reg_d == REG_WRAM;
    assign oam_we  = r_busy && wr && reg_d == REG_OAM;
    assign hram_we = r_busy && wr && reg_d == REG_HRAM;
    assign io_we   = r_busy && reg_d == REG_IO && iod.wen;

    hmm_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_BYTES)) u_vram (
        .i_clk(i_clk), .i_we(vram_we), .i_addr(vidx[VAW-1:0]),
        .i_wdata(r_req.write_data), .o_rdata(vram_q));
    hmm_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_wram (
        .i_clk(i_clk), .i_we(wram_we), .i_addr(widx[WAW-1:0]),
        .i_wdata(r_req.write_data), .o_rdata(wram_q));
    hmm_ram #(.WIDTH(8), .DEPTH(256)) u_oam (
        .i_clk(i_clk), .i_we(oam_we), .i_addr(mreq.address[7:0]),
        .i_wdata(r_req.write_data), .o_rdata(oam_q));
    hmm_ram #(.WIDTH(8), .DEPTH(128)) u_hram (
        .i_clk(i_clk), .i_we(hram_we), .i_addr(mreq.address[6:0]),
        .i_wdata(r_req.write_data), .o_rdata(hram_q));
    hmm_ram #(.WIDTH(8), .DEPTH(128)) u_io (
        .i_clk(i_clk), .i_we(io_we), .i_addr(mreq.address[6:0]),
        .i_wdata(io_wdata), .o_rdata(io_q));

    always_comb begin
        n_rsp = '0;
        n_rsp.region = reg_d;
        case (reg_d)
            REG_ROM:    n_rsp.forward_kind = FWD_CART;
            REG_EXTRAM: n_rsp.forward_kind = FWD_EXTRAM;
            REG_VRAM:   n_rsp.read_data = vram_q;
            REG_WRAM:   n_rsp.read_data = wram_q;
            REG_OAM:    n_rsp.read_data = oam_q;
            REG_HRAM:   n_rsp.read_data = hram_q;
            REG_IE:     n_rsp.read_data = r_ie;
            REG_ECHO:   n_rsp.status = ST_DENIED;
            REG_UNUSED: n_rsp.status = (wr && r_req.write_data == 8'h00) ? ST_OK : ST_DENIED;
            REG_IO: begin
                n_rsp.status        = iod.status;
                n_rsp.forward_kind  = iod.fwd;
                n_rsp.divider_reset = iod.divr;
                case (iod.src)
                    SRC_MEM:  n_rsp.read_data = io_old & iod.rmask;
                    SRC_DIV:  n_rsp.read_data = r_req.divider_now;
                    SRC_LINE: n_rsp.read_data = r_doctor ? LINE_FORCE : r_req.line_now;
                    default:  n_rsp.read_data = 8'h00;
                endcase
            end
            default: n_rsp.read_data = 8'h00;
        endcase
        if (wr || n_rsp.status != ST_OK || n_rsp.forward_kind != FWD_NONE)
            n_rsp.read_data = 8'h00;
    end

    always_comb begin
        n_busy   = accept ? 1'b1 : 1'b0;
        n_ovalid = r_busy ? 1'b1 : (r_ovalid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_ie     <= 8'h00;
            for (int k = 0; k < 128; k++) r_io_valid[k] <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            if (r_busy && wr && reg_d == REG_IE) r_ie <= r_req.write_data;
            if (io_we) r_io_valid[a[6:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
        if (r_busy) r_rsp <= n_rsp;
    end
endmodule

// ===== dv/handheld_memory_map_io_registers_checker.sv =====
// Checker that predicts each bus access result of the memory map block and compares it.
`timescale 1ns / 1ps
module handheld_memory_map_io_registers_checker
    import hmm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  t_req        i_req,
    input  logic        o_valid,
    input  logic        i_stall,
    input  t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_count,
    output int          access_count
);

    logic [7:0] vram_model [VideoRamBytes];
    logic [7:0] wram_model [WorkRamBytes];
    logic [7:0] oam_model  [160];
    logic [7:0] hram_model [127];
    logic [7:0] io_model   [128];
    logic [7:0] ie_model;
    logic       line_forced;
    t_rsp       expected_rsp [$];

    function automatic t_status io_store(input logic [6:0] off, input logic [7:0] d,
                                         inout t_fwd fwd, inout logic divr);
        case (off)
            7'h00: io_model[0] = (io_model[0] & 8'hCF) | (d & 8'h30);
            7'h04: begin io_model[4] = 8'h00; divr = 1'b1; end
            7'h07: io_model[7] = d & 8'h07;
            7'h14, 7'h19: io_model[off] = d & 8'hC7;
            7'h26: io_model[off] = (io_model[off] & 8'h7F) | (d & 8'h80);
            7'h41: io_model[off] = d & 8'h78;
            7'h44: return ST_RONLY;
            7'h46: begin io_model[off] = d; fwd = FWD_DMA; end
            7'h50: begin io_model[off] = d; fwd = FWD_BOOT; end
            7'h4D, 7'h7F: ;
            7'h01, 7'h02, 7'h05, 7'h06, 7'h0F, 7'h10, 7'h11, 7'h12, 7'h13, 7'h16,
            7'h17, 7'h18, 7'h1A, 7'h1B, 7'h1C, 7'h1D, 7'h1E, 7'h20, 7'h21, 7'h22,
            7'h23, 7'h24, 7'h25, 7'h40, 7'h42, 7'h43, 7'h45, 7'h47, 7'h48, 7'h49,
            7'h4A, 7'h4B: io_model[off] = d;
            default: begin
                if (off >= 7'h30 && off <= 7'h3F) io_model[off] = d;
                else return ST_DENIED;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic t_status io_fetch(input logic [6:0] off, input t_req rq,
                                         output logic [7:0] d);
        d = 8'h00;
        case (off)
            7'h04: d = rq.divider_now;
            7'h44: d = line_forced ? LINE_FORCE : rq.line_now;
            7'h4D: ;
            7'h07: d = io_model[off] & 8'h07;
            7'h11, 7'h16: d = io_model[off] & 8'hC0;
            7'h14, 7'h19, 7'h1E, 7'h23: d = io_model[off] & 8'h40;
            7'h13, 7'h18, 7'h1B, 7'h1D, 7'h20: return ST_WONLY;
            7'h00, 7'h01, 7'h02, 7'h05, 7'h06, 7'h0F, 7'h10, 7'h12, 7'h17, 7'h1A,
            7'h1C, 7'h21, 7'h22, 7'h24, 7'h25, 7'h26, 7'h40, 7'h41, 7'h42, 7'h43,
            7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B: d = io_model[off];
            default: begin
                if (off >= 7'h30 && off <= 7'h3F) d = io_model[off];
                else return ST_DENIED;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic t_rsp decode_access(input t_req rq);
        t_rsp    r;
        logic    wr;
        logic [15:0] a;
        logic [15:0] vofs;
        logic [15:0] wofs;
        t_region reg_id;
        t_status st;
        t_fwd    fwd;
        logic    divr;
        logic [7:0] rd;
        wr = rq.req_type;
        a = rq.address;
        vofs = a - 16'h8000;
        wofs = a - 16'hC000;
        st = ST_OK;
        fwd = FWD_NONE;
        divr = 1'b0;
        rd = 8'h00;
        if (a <= 16'h7FFF) begin
            reg_id = REG_ROM; fwd = FWD_CART;
        end else if (a <= 16'h9FFF) begin
            reg_id = REG_VRAM;
            if (wr) vram_model[vofs[12:0]] = rq.write_data;
            else rd = vram_model[vofs[12:0]];
        end else if (a <= 16'hBFFF) begin
            reg_id = REG_EXTRAM; fwd = FWD_EXTRAM;
        end else if (a <= 16'hDFFF) begin
            reg_id = REG_WRAM;
            if (wr) wram_model[wofs[12:0]] = rq.write_data;
            else rd = wram_model[wofs[12:0]];
        end else if (a <= 16'hFDFF) begin
            reg_id = REG_ECHO; st = ST_DENIED;
        end else if (a <= 16'hFE9F) begin
            reg_id = REG_OAM;
            if (wr) oam_model[a[7:0]] = rq.write_data;
            else rd = oam_model[a[7:0]];
        end else if (a <= 16'hFEFF) begin
            reg_id = REG_UNUSED;
            st = (wr && rq.write_data == 8'h00) ? ST_OK : ST_DENIED;
        end else if (a <= 16'hFF7F) begin
            reg_id = REG_IO;
            if (wr) st = io_store(a[6:0], rq.write_data, fwd, divr);
            else st = io_fetch(a[6:0], rq, rd);
        end else if (a <= 16'hFFFE) begin
            reg_id = REG_HRAM;
            if (wr) hram_model[a[6:0]] = rq.write_data;
            else rd = hram_model[a[6:0]];
        end else begin
            reg_id = REG_IE;
            if (wr) ie_model = rq.write_data;
            else rd = ie_model;
        end
        if (wr || st != ST_OK || fwd != FWD_NONE) rd = 8'h00;
        r.read_data = rd;
        r.region = reg_id;
        r.status = st;
        r.forward_kind = fwd;
        r.divider_reset = divr;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (io_model[k]) io_model[k] = 8'h00;
            io_model[0] = JOYP_RESET;
            ie_model = 8'h00;
            line_forced = 1'b0;
            fail_count = 0;
            access_count = 0;
            expected_rsp.delete();
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite && paddr == CFG_DOCTOR_MODE)
                line_forced = pwdata[0];
            if (o_valid && !i_stall) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, o_rsp);
                    fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (want !== o_rsp) begin
                        $display("%0t: mismatch expected rd=%h reg=%0d st=%0d fwd=%0d div=%0d",
                                 $time, want.read_data, want.region, want.status,
                                 want.forward_kind, want.divider_reset);
                        $display("%0t:          actual   rd=%h reg=%0d st=%0d fwd=%0d div=%0d",
                                 $time, o_rsp.read_data, o_rsp.region, o_rsp.status,
                                 o_rsp.forward_kind, o_rsp.divider_reset);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_rsp.push_back(decode_access(i_req));
                access_count++;
            end
            pending_count = expected_rsp.size();
        end
    end

endmodule

// ===== dv/handheld_memory_map_io_registers_test.sv =====
// Top of the memory map testbench: drives bus accesses and APB writes, gives the verdict.
`timescale 1ns / 1ps
module handheld_memory_map_io_registers_test;
    import hmm_pkg::*;

    localparam int CycleLimit = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_req        i_req = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_rsp        o_rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          access_count;
    int          cycle_count = 0;
    int          idle_pct = 30;
    bit          hold_rx = 1'b0;
    // Addresses written so far, so reads of RAM never hit an unwritten byte.
    logic [15:0] written_addr [$];
    bit          written_map [int];

    handheld_memory_map_io_registers dut (.*);

    handheld_memory_map_io_registers_checker checker_i (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver stall: random, or held for a long stretch when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= hold_rx || ($urandom_range(99) < idle_pct);
    end

    function automatic bit is_ram(input logic [15:0] a);
        return (a >= 16'h8000 && a <= 16'h9FFF) || (a >= 16'hC000 && a <= 16'hDFFF) ||
               (a >= 16'hFE00 && a <= 16'hFE9F) || (a >= 16'hFF80 && a <= 16'hFFFE);
    endfunction

    // The valid line stays high from one transaction into the next when there is
    // no idle cycle between them; it drops on an idle cycle or in drain.
    task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
        t_req rq;
        if (!wr && is_ram(a) && !written_map.exists(a)) wr = 1'b1;
        if (wr && is_ram(a) && !written_map.exists(a)) begin
            written_map[a] = 1'b1;
            written_addr.push_back(a);
        end
        rq.req_type = wr;
        rq.address = a;
        rq.write_data = d;
        rq.divider_now = 8'($urandom);
        rq.line_now = 8'($urandom);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req <= rq;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_line_force(input logic v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= CFG_DOCTOR_MODE;
        pwdata <= {31'($urandom), v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] pick_address;
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) return 16'hFF00 | 16'($urandom_range(127));
        if (sel < 45 && written_addr.size() != 0)
            return written_addr[$urandom_range(written_addr.size() - 1)];
        if (sel < 55) return 16'h8000 + 16'($urandom_range(8191));
        if (sel < 65) return 16'hC000 + 16'($urandom_range(8191));
        if (sel < 72) return 16'hFE00 + 16'($urandom_range(255));
        if (sel < 80) return 16'hFF80 + 16'($urandom_range(127));
        return 16'($urandom);
    endfunction

    task automatic random_phase(input int count);
        logic [15:0] a;
        for (int n = 0; n < count; n++) begin
            a = pick_address();
            send_access(1'($urandom_range(1)), a,
                        ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);

        // Directed: region edges, masked and special I/O registers.
        idle_pct = 0;
        send_access(1'b1, 16'h0000, 8'hFF);
        send_access(1'b0, 16'h7FFF, 8'h00);
        send_access(1'b1, 16'h8000, 8'hA5);
        send_access(1'b0, 16'h8000, 8'h00);
        send_access(1'b1, 16'hBFFF, 8'h12);
        send_access(1'b1, 16'hDFFF, 8'h5A);
        send_access(1'b0, 16'hDFFF, 8'h00);
        send_access(1'b0, 16'hE000, 8'h00);
        send_access(1'b1, 16'hFE9F, 8'h3C);
        send_access(1'b1, 16'hFEA0, 8'h00);
        send_access(1'b1, 16'hFEFF, 8'h01);
        send_access(1'b0, 16'hFF00, 8'h00);
        send_access(1'b1, 16'hFF00, 8'hFF);
        send_access(1'b1, 16'hFF04, 8'h77);
        send_access(1'b1, 16'hFF07, 8'hFF);
        send_access(1'b0, 16'hFF07, 8'h00);
        send_access(1'b1, 16'hFF26, 8'hFF);
        send_access(1'b1, 16'hFF41, 8'hFF);
        send_access(1'b1, 16'hFF44, 8'h11);
        send_access(1'b0, 16'hFF13, 8'h00);
        send_access(1'b1, 16'hFF46, 8'hC0);
        send_access(1'b1, 16'hFF50, 8'h01);
        send_access(1'b0, 16'hFF50, 8'h00);
        send_access(1'b1, 16'hFFFE, 8'h99);
        send_access(1'b1, 16'hFFFF, 8'h1F);
        send_access(1'b0, 16'hFFFF, 8'h00);

        idle_pct = 30;
        random_phase(400);
        set_line_force(1'b1);
        send_access(1'b0, 16'hFF44, 8'h00);
        random_phase(400);

        // Long receiver hold-off so the block backs up on its input.
        fork
            begin
                hold_rx = 1'b1;
                repeat (60) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            random_phase(30);
        join
        drain();

        idle_pct = 0;
        random_phase(300);
        idle_pct = 30;
        set_line_force(1'b0);
        random_phase(600);

        drain();
        repeat (10) @(negedge i_clk);
        $display("Ran %0d bus accesses over every region, masked I/O registers and both",
                 access_count);
        $display("line-register modes, with random idling and a long receiver hold-off.");
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hmm_pkg.sv
sv/hmm_ram.sv
sv/handheld_memory_map_io_registers.sv
dv/handheld_memory_map_io_registers_checker.sv
dv/handheld_memory_map_io_registers_test.sv
